### rtl/core/lidp_pkg.sv
// Shared types and constants of the line-identification sub-option parser.
package lidp_pkg;

  // Default number of entries in the queue between the front and the back.
  localparam int unsigned QUEUE_DEPTH = 4;

  // One entry of work: an optional attribute result and an optional status result.
  typedef struct packed {
    logic        attr_vld;
    logic [4:0]  attr_code;
    logic [31:0] attr_value;
    logic        attr_end;
    logic        attr_empty;
    logic        stat_vld;
    logic        stat_bad;
  } op_t;

endpackage

### rtl/core/lidp_front.sv
// Front part: walks the tag bytes one per cycle while the queue is not full and emits result work into the queue.
module lidp_front import lidp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  input  logic [7:0]  in_data_byte,
  input  logic        in_first_byte,
  input  logic [15:0] in_tag_length,
  input  logic        in_mode,
  input  logic        q_full,
  output logic        q_push,
  output op_t         q_op
);

  typedef enum logic [2:0] {
    PH_IDLE, PH_ENT, PH_ID, PH_LEN, PH_PAY, PH_ERR
  } phase_t;

  typedef enum logic [2:0] {
    K_NONE, K_TEXT, K_NUM, K_ENCAP, K_FLAG
  } kind_t;

  localparam logic [7:0]  ID_CIRCUIT   = 8'h01;
  localparam logic [7:0]  ID_REMOTE    = 8'h02;
  localparam logic [7:0]  ID_NUM_LO    = 8'h81;
  localparam logic [7:0]  ID_NUM_HI    = 8'h8E;
  localparam logic [7:0]  ID_ACC_LO    = 8'h85;
  localparam logic [7:0]  ID_ENCAP     = 8'h90;
  localparam logic [7:0]  ID_SESSION   = 8'hFE;
  localparam logic [7:0]  NUM_BASE     = 8'h7F;
  localparam logic [7:0]  TEXT_MAX     = 8'd63;
  localparam logic [7:0]  NUM_LEN      = 8'd4;
  localparam logic [7:0]  ENCAP_LEN    = 8'd3;
  localparam logic [16:0] ENT_BYTES    = 17'd4;
  localparam logic [4:0]  CODE_CIRCUIT = 5'd0;
  localparam logic [4:0]  CODE_REMOTE  = 5'd1;
  localparam logic [4:0]  CODE_ENCAP   = 5'd16;
  localparam logic [4:0]  CODE_SESSION = 5'd17;

  function automatic kind_t kind_of(input logic [7:0] id, input logic access);
    kind_t k;
    k = K_NONE;
    if (access && (id inside {[ID_ACC_LO:ID_ENCAP]})) k = K_NONE;
    else if (id inside {ID_CIRCUIT, ID_REMOTE})       k = K_TEXT;
    else if (id inside {[ID_NUM_LO:ID_NUM_HI]})       k = K_NUM;
    else if (id == ID_ENCAP)                          k = K_ENCAP;
    else if (id == ID_SESSION)                        k = K_FLAG;
    return k;
  endfunction

  function automatic logic [4:0] code_of(input logic [7:0] id);
    logic [7:0] d;
    logic [4:0] c;
    d = id - NUM_BASE;
    if (id == ID_CIRCUIT)                        c = CODE_CIRCUIT;
    else if (id == ID_REMOTE)                    c = CODE_REMOTE;
    else if (id inside {[ID_NUM_LO:ID_NUM_HI]})  c = d[4:0];
    else if (id == ID_ENCAP)                     c = CODE_ENCAP;
    else                                         c = CODE_SESSION;
    return c;
  endfunction

  function automatic logic len_ok(input kind_t k, input logic [7:0] len);
    logic ok;
    case (k)
      K_TEXT:  ok = (len <= TEXT_MAX);
      K_NUM:   ok = (len == NUM_LEN);
      K_ENCAP: ok = (len == ENCAP_LEN);
      K_FLAG:  ok = (len == 8'd0);
      default: ok = 1'b1;
    endcase
    return ok;
  endfunction

  phase_t      phase_r, phase_nxt, phase_e;
  logic [15:0] byte_count_r, byte_count_nxt, pos_e;
  logic [15:0] tag_total_r, tag_total_nxt, tot_e;
  logic        mode_r, mode_nxt, mode_e;
  logic [7:0]  option_id_r, option_id_nxt, opt_e;
  logic [7:0]  payload_left_r, payload_left_nxt, pl_e;
  logic [31:0] acc_r, acc_nxt, acc_e;
  logic        skipping_r, skipping_nxt, skip_e;

  logic        take, restart, last;
  logic [16:0] pos_inc;
  logic [15:0] rem;
  kind_t       kind;
  op_t         op;

  assign take    = in_push && !q_full;
  assign restart = take && in_first_byte;

  always_comb begin
    // a first byte opens a fresh tag before the byte is processed
    if (restart) begin
      tot_e   = (in_tag_length == 16'd0) ? 16'd1 : in_tag_length;
      mode_e  = in_mode;
      pos_e   = 16'd0;
      phase_e = PH_ENT;
      opt_e   = 8'd0;
      pl_e    = 8'd0;
      acc_e   = 32'd0;
      skip_e  = 1'b0;
    end else begin
      tot_e   = tag_total_r;
      mode_e  = mode_r;
      pos_e   = byte_count_r;
      phase_e = phase_r;
      opt_e   = option_id_r;
      pl_e    = payload_left_r;
      acc_e   = acc_r;
      skip_e  = skipping_r;
    end

    pos_inc = {1'b0, pos_e} + 17'd1;
    last    = (pos_inc >= {1'b0, tot_e});
    rem     = last ? 16'd0 : (tot_e - pos_e - 16'd1);
    kind    = kind_of(opt_e, mode_e);

    tag_total_nxt    = tot_e;
    mode_nxt         = mode_e;
    byte_count_nxt   = pos_e;
    phase_nxt        = phase_e;
    option_id_nxt    = opt_e;
    payload_left_nxt = pl_e;
    acc_nxt          = acc_e;
    skipping_nxt     = skip_e;
    op               = '0;

    if (take && phase_e != PH_IDLE) begin
      case (phase_e)
        PH_ENT: begin
          if (pos_inc >= ENT_BYTES) phase_nxt = PH_ID;
        end
        PH_ID: begin
          option_id_nxt = in_data_byte;
          phase_nxt     = last ? PH_ERR : PH_LEN;
        end
        PH_LEN: begin
          if ({8'd0, in_data_byte} > rem || !len_ok(kind, in_data_byte)) begin
            phase_nxt = PH_ERR;
          end else if (in_data_byte == 8'd0) begin
            if (kind != K_NONE) begin
              op.attr_vld   = 1'b1;
              op.attr_code  = code_of(opt_e);
              op.attr_end   = 1'b1;
              op.attr_empty = 1'b1;
            end
            phase_nxt = PH_ID;
          end else begin
            payload_left_nxt = in_data_byte;
            skipping_nxt     = (kind == K_NONE);
            acc_nxt          = 32'd0;
            phase_nxt        = PH_PAY;
          end
        end
        PH_PAY: begin
          payload_left_nxt = pl_e - 8'd1;
          if (!skip_e) begin
            if (kind == K_NUM) begin
              acc_nxt = {acc_e[23:0], in_data_byte};
              if (payload_left_nxt == 8'd0) begin
                op.attr_vld   = 1'b1;
                op.attr_code  = code_of(opt_e);
                op.attr_value = acc_nxt;
                op.attr_end   = 1'b1;
              end
            end else begin
              op.attr_vld   = 1'b1;
              op.attr_code  = code_of(opt_e);
              op.attr_value = {24'd0, in_data_byte};
              op.attr_end   = (payload_left_nxt == 8'd0);
            end
          end
          if (payload_left_nxt == 8'd0) phase_nxt = PH_ID;
        end
        default: ;
      endcase

      byte_count_nxt = pos_inc[15:0];
      if (last) begin
        op.stat_vld = 1'b1;
        op.stat_bad = (phase_nxt == PH_ERR);
        phase_nxt   = PH_IDLE;
      end
    end
  end

  assign q_push = take && (op.attr_vld || op.stat_vld);
  assign q_op   = op;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_IDLE;
      byte_count_r   <= 16'd0;
      tag_total_r    <= 16'd0;
      mode_r         <= 1'b0;
      option_id_r    <= 8'd0;
      payload_left_r <= 8'd0;
      acc_r          <= 32'd0;
      skipping_r     <= 1'b0;
    end else begin
      phase_r        <= phase_nxt;
      byte_count_r   <= byte_count_nxt;
      tag_total_r    <= tag_total_nxt;
      mode_r         <= mode_nxt;
      option_id_r    <= option_id_nxt;
      payload_left_r <= payload_left_nxt;
      acc_r          <= acc_nxt;
      skipping_r     <= skipping_nxt;
    end
  end

endmodule

### rtl/core/lidp_back.sv
// Back part: queue of pending work and the result sequencer that drives the output side.
module lidp_back import lidp_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_push,
  input  op_t         q_op,
  output logic        q_full,
  output logic        out_empty,
  input  logic        out_pop,
  output logic        out_is_attribute,
  output logic [4:0]  out_attr_code,
  output logic [31:0] out_attr_value,
  output logic        out_attr_end,
  output logic        out_attr_empty,
  output logic        out_tag_done,
  output logic        out_tag_invalid
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

  op_t           mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r, count_nxt;
  logic          second_r;
  op_t           head;
  logic          show_attr, take, deq;

  assign q_full    = (count_r == CW'(DEPTH));
  assign out_empty = (count_r == '0);
  assign head      = mem_r[rd_ptr_r];
  // the attribute part of a head entry goes out before its status part
  assign show_attr = head.attr_vld && !second_r;
  assign take      = out_pop && !out_empty;
  assign deq       = take && !(show_attr && head.stat_vld);

  assign out_is_attribute = show_attr;
  assign out_attr_code    = show_attr ? head.attr_code : 5'd0;
  assign out_attr_value   = show_attr ? head.attr_value : 32'd0;
  assign out_attr_end     = show_attr && head.attr_end;
  assign out_attr_empty   = show_attr && head.attr_empty;
  assign out_tag_done     = !show_attr;
  assign out_tag_invalid  = !show_attr && head.stat_bad;

  always_comb begin
    count_nxt = count_r;
    if (q_push && !deq)      count_nxt = count_r + CW'(1);
    else if (!q_push && deq) count_nxt = count_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (q_push) mem_r[wr_ptr_r] <= q_op;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
      second_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (q_push) wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PW'(1);
      if (deq) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PW'(1);
        second_r <= 1'b0;
      end else if (take) begin
        second_r <= 1'b1;
      end
    end
  end

endmodule

### rtl/core/line_id_subtlv_parser.sv
// Top level of the line-identification sub-option parser.
// Takes one tag byte per cycle (push/full) and gives attribute and status
// items through a queue-style output (empty/pop). A byte is taken whenever the
// work queue has room; a byte that yields both an attribute and the final
// status needs two output pops, so under a steady run of such bytes the
// output side sets the sustained rate, and the work queue of QUEUE_DEPTH
// entries between the byte walker and the result sequencer absorbs short
// output stalls. Empty goes low in the cycle after a push that yields work.
module line_id_subtlv_parser import lidp_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_data_byte,
  input  logic        in_first_byte,
  input  logic [15:0] in_tag_length,
  input  logic        in_mode,
  output logic        out_empty,
  input  logic        out_pop,
  output logic        out_is_attribute,
  output logic [4:0]  out_attr_code,
  output logic [31:0] out_attr_value,
  output logic        out_attr_end,
  output logic        out_attr_empty,
  output logic        out_tag_done,
  output logic        out_tag_invalid
);

  logic q_push, q_full;
  op_t  q_op;

  assign in_full = q_full;

  lidp_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_data_byte  (in_data_byte),
    .in_first_byte (in_first_byte),
    .in_tag_length (in_tag_length),
    .in_mode       (in_mode),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_op          (q_op)
  );

  lidp_back #(.DEPTH(DEPTH)) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_push           (q_push),
    .q_op             (q_op),
    .q_full           (q_full),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_is_attribute (out_is_attribute),
    .out_attr_code    (out_attr_code),
    .out_attr_value   (out_attr_value),
    .out_attr_end     (out_attr_end),
    .out_attr_empty   (out_attr_empty),
    .out_tag_done     (out_tag_done),
    .out_tag_invalid  (out_tag_invalid)
  );

endmodule
